>>> rtl/dfd_pkg.sv
// ----------------------------------------------------------------------------
// dfd_pkg
// Shared types and constants for the FAT12 directory entry decoder.
// ----------------------------------------------------------------------------
package dfd_pkg;

  localparam int unsigned PosW = 5;

  localparam logic [PosW-1:0] POS_LEAD      = 5'd0;
  localparam logic [PosW-1:0] POS_ATTR      = 5'd11;
  localparam logic [PosW-1:0] POS_TIME_LO   = 5'd14;
  localparam logic [PosW-1:0] POS_TIME_HI   = 5'd15;
  localparam logic [PosW-1:0] POS_DATE_LO   = 5'd16;
  localparam logic [PosW-1:0] POS_DATE_HI   = 5'd17;
  localparam logic [PosW-1:0] POS_CLUST_LO  = 5'd26;
  localparam logic [PosW-1:0] POS_CLUST_HI  = 5'd27;
  localparam logic [PosW-1:0] POS_SIZE_B0   = 5'd28;
  localparam logic [PosW-1:0] POS_SIZE_B1   = 5'd29;
  localparam logic [PosW-1:0] POS_SIZE_B2   = 5'd30;
  localparam logic [PosW-1:0] POS_SIZE_B3   = 5'd31;
  localparam logic [PosW-1:0] POS_LAST      = 5'd31;

  localparam logic [7:0]  LEAD_END      = 8'h00;
  localparam logic [7:0]  LEAD_DELETED  = 8'hE5;
  localparam logic [7:0]  ATTR_LONGNAME = 8'h0F;
  localparam int unsigned ATTR_DIR_BIT  = 4;
  localparam logic [11:0] YEAR_BASE     = 12'd1980;

  typedef enum logic [2:0] {
    KIND_FILE      = 3'd0,
    KIND_DIR       = 3'd1,
    KIND_DELETED   = 3'd2,
    KIND_LONGNAME  = 3'd3,
    KIND_RESERVED  = 3'd4,
    KIND_END       = 3'd5,
    KIND_AFTER_END = 3'd6
  } kind_e;

  typedef struct packed {
    logic        ended;
    logic [7:0]  lead;
    logic [7:0]  attr;
    logic [15:0] tm;
    logic [15:0] dt;
    logic [15:0] cluster;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    kind_e       entry_kind;
    logic [7:0]  attributes;
    logic [15:0] first_cluster;
    logic [31:0] file_size;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } result_t;

endpackage

>>> rtl/dfd_capture.sv
// ----------------------------------------------------------------------------
// dfd_capture
// Byte position counter and field capture registers for one directory entry.
// ----------------------------------------------------------------------------
module dfd_capture import dfd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   data_byte_i,
  input  logic         start_of_directory_i,
  output logic         last_o,
  output entry_t       entry_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic            ended_q, ended_d, ended_eff;
  logic [7:0]      lead_q, lead_d;
  logic [7:0]      attr_q, attr_d;
  logic [15:0]     time_q, time_d;
  logic [15:0]     date_q, date_d;
  logic [15:0]     clust_q, clust_d;
  logic [31:0]     size_q, size_d;
  logic            last;

  assign pos_eff   = start_of_directory_i ? '0 : pos_q;
  assign ended_eff = start_of_directory_i ? 1'b0 : ended_q;
  assign last      = accept_i && (pos_eff == POS_LAST);

  always_comb begin
    lead_d  = lead_q;
    attr_d  = attr_q;
    time_d  = time_q;
    date_d  = date_q;
    clust_d = clust_q;
    size_d  = size_q;
    case (pos_eff)
      POS_LEAD:     lead_d          = data_byte_i;
      POS_ATTR:     attr_d          = data_byte_i;
      POS_TIME_LO:  time_d[7:0]     = data_byte_i;
      POS_TIME_HI:  time_d[15:8]    = data_byte_i;
      POS_DATE_LO:  date_d[7:0]     = data_byte_i;
      POS_DATE_HI:  date_d[15:8]    = data_byte_i;
      POS_CLUST_LO: clust_d[7:0]    = data_byte_i;
      POS_CLUST_HI: clust_d[15:8]   = data_byte_i;
      POS_SIZE_B0:  size_d[7:0]     = data_byte_i;
      POS_SIZE_B1:  size_d[15:8]    = data_byte_i;
      POS_SIZE_B2:  size_d[23:16]   = data_byte_i;
      POS_SIZE_B3:  size_d[31:24]   = data_byte_i;
      default: ;
    endcase
    pos_d   = pos_eff + 1'b1;
    ended_d = ended_eff | (last && (lead_q == LEAD_END));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ended_q <= 1'b0;
      lead_q  <= '0;
      attr_q  <= '0;
      time_q  <= '0;
      date_q  <= '0;
      clust_q <= '0;
      size_q  <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      ended_q <= ended_d;
      lead_q  <= lead_d;
      attr_q  <= attr_d;
      time_q  <= time_d;
      date_q  <= date_d;
      clust_q <= clust_d;
      size_q  <= size_d;
    end
  end

  assign last_o = last;

  always_comb begin
    entry_o         = '0;
    entry_o.ended   = ended_eff;
    entry_o.lead    = lead_q;
    entry_o.attr    = attr_q;
    entry_o.tm      = time_q;
    entry_o.dt      = date_q;
    entry_o.cluster = clust_q;
    entry_o.size    = size_d;
  end

endmodule

>>> rtl/dfd_classify.sv
// ----------------------------------------------------------------------------
// dfd_classify
// Classify a captured entry and unpack cluster, size, date and time.
// ----------------------------------------------------------------------------
module dfd_classify import dfd_pkg::*; (
  input  entry_t  entry_i,
  output result_t result_o
);

  kind_e kind;
  logic  keep;

  always_comb begin
    if (entry_i.ended) begin
      kind = KIND_AFTER_END;
    end else if (entry_i.lead == LEAD_END) begin
      kind = KIND_END;
    end else if (entry_i.lead == LEAD_DELETED) begin
      kind = KIND_DELETED;
    end else if (entry_i.attr == ATTR_LONGNAME) begin
      kind = KIND_LONGNAME;
    end else if (entry_i.cluster[15:1] == 15'd0) begin
      kind = KIND_RESERVED;
    end else if (entry_i.attr[ATTR_DIR_BIT]) begin
      kind = KIND_DIR;
    end else begin
      kind = KIND_FILE;
    end
    keep = (kind == KIND_FILE) || (kind == KIND_DIR);

    result_o            = '0;
    result_o.entry_kind = kind;
    if (keep) begin
      result_o.attributes    = entry_i.attr;
      result_o.first_cluster = entry_i.cluster;
      result_o.file_size     = entry_i.size;
      result_o.year          = YEAR_BASE + {5'd0, entry_i.dt[15:9]};
      result_o.month         = entry_i.dt[8:5];
      result_o.day           = entry_i.dt[4:0];
      result_o.hour          = entry_i.tm[15:11];
      result_o.minute        = entry_i.tm[10:5];
      result_o.second        = {entry_i.tm[4:0], 1'b0};
    end
  end

endmodule

>>> rtl/dfd_out_buf.sv
// ----------------------------------------------------------------------------
// dfd_out_buf
// Result register with a skid stage behind it.
// ----------------------------------------------------------------------------
module dfd_out_buf import dfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    pop;

  assign pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= result_i;
      end else begin
        skid_q <= result_i;
      end
    end
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && pop |=> !skid_valid_q && out_valid_q)
    else $error("skid stage did not drain into the output register");

endmodule

>>> rtl/fat12_directory_entry_decoder.sv
// ----------------------------------------------------------------------------
// fat12_directory_entry_decoder
// Decode FAT12 directory entries from a byte stream.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o carry one raw byte of the directory
// region per transaction, with start_of_directory_i set on the first byte of
// a new directory (clears the byte position and the end-of-directory flag).
// Output channel: out_valid_o / out_ready_i carry one entry result per 32
// input bytes: kind, attributes, start cluster, size and unpacked date/time.
// Kinds other than file or directory report all other fields as zero.
// An entry result enters the result register (the skid stage if that is held)
// as its 32nd byte is accepted. One byte per cycle while in_ready_o is high.
// A result register plus a skid stage decouple the channels; in_ready_o
// drops only when both hold a result, i.e. after the receiver stalls
// across two results (64 bytes).
// Reset clears the byte position, the captured fields, the end flag and the
// valid flags of both output stages.
// ----------------------------------------------------------------------------
module fat12_directory_entry_decoder import dfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_directory_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  entry_kind_o,
  output logic [7:0]  attributes_o,
  output logic [15:0] first_cluster_o,
  output logic [31:0] file_size_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic    accept, last, space;
  entry_t  entry;
  result_t result, result_q;

  assign accept     = in_valid_i && space;
  assign in_ready_o = space;

  dfd_capture u_capture (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .accept_i             (accept),
    .data_byte_i          (data_byte_i),
    .start_of_directory_i (start_of_directory_i),
    .last_o               (last),
    .entry_o              (entry)
  );

  dfd_classify u_classify (
    .entry_i  (entry),
    .result_o (result)
  );

  dfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (last),
    .result_i    (result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_q)
  );

  assign entry_kind_o    = result_q.entry_kind;
  assign attributes_o    = result_q.attributes;
  assign first_cluster_o = result_q.first_cluster;
  assign file_size_o     = result_q.file_size;
  assign year_o          = result_q.year;
  assign month_o         = result_q.month;
  assign day_o           = result_q.day;
  assign hour_o          = result_q.hour;
  assign minute_o        = result_q.minute;
  assign second_o        = result_q.second;

  a_other_kinds_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_kind_o != KIND_FILE && entry_kind_o != KIND_DIR |->
      attributes_o == '0 && first_cluster_o == '0 && file_size_o == '0 &&
      year_o == '0 && month_o == '0 && day_o == '0 && hour_o == '0 &&
      minute_o == '0 && second_o == '0)
    else $error("non file entry carries field data");

  a_year_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entry_kind_o == KIND_FILE || entry_kind_o == KIND_DIR) |->
      year_o >= YEAR_BASE && first_cluster_o[15:1] != '0)
    else $error("file entry with bad year or reserved cluster");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the FAT12 directory entry decoder against a cycle-free predictor.
// A queue of directory bytes (crafted entries first, then random directories
// with end markers, deleted, long-name and reserved-cluster entries, plus
// broken fragments) feeds a driver with random idle bursts. A monitor with
// random stalls compares each entry result with the predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import dfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       sod;
  } dir_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_data = 8'h00;
  logic        in_sod = 1'b0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [2:0]  entry_kind_o;
  logic [7:0]  attributes_o;
  logic [15:0] first_cluster_o;
  logic [31:0] file_size_o;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  dir_byte_t dir_bytes_q[$];
  result_t   entry_results_q[$];
  dir_byte_t drv_item;
  result_t   got_entry;
  result_t   want_entry;

  logic [4:0]  ent_pos = '0;
  logic [7:0]  ent_lead = '0;
  logic [7:0]  ent_attr = '0;
  logic [15:0] ent_time = '0;
  logic [15:0] ent_date = '0;
  logic [15:0] ent_cluster = '0;
  logic [31:0] ent_size = '0;
  logic        dir_ended = 1'b0;

  int   total_bytes;
  int   accepted_n = 0;
  int   entries_seen = 0;
  int   errors = 0;
  int   in_gap = 0;
  int   out_stall = 0;
  logic quiet = 1'b0;
  logic in_idle_en = 1'b1;
  logic out_idle_en = 1'b1;

  fat12_directory_entry_decoder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (in_data),
    .start_of_directory_i(in_sod),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .entry_kind_o        (entry_kind_o),
    .attributes_o        (attributes_o),
    .first_cluster_o     (first_cluster_o),
    .file_size_o         (file_size_o),
    .year_o              (year_o),
    .month_o             (month_o),
    .day_o               (day_o),
    .hour_o              (hour_o),
    .minute_o            (minute_o),
    .second_o            (second_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void decode_byte(logic [7:0] b, logic sod);
    result_t    r;
    logic [4:0] p;
    if (sod) begin
      ent_pos = '0;
      dir_ended = 1'b0;
    end
    p = ent_pos;
    case (p)
      POS_LEAD:     ent_lead = b;
      POS_ATTR:     ent_attr = b;
      POS_TIME_LO:  ent_time[7:0] = b;
      POS_TIME_HI:  ent_time[15:8] = b;
      POS_DATE_LO:  ent_date[7:0] = b;
      POS_DATE_HI:  ent_date[15:8] = b;
      POS_CLUST_LO: ent_cluster[7:0] = b;
      POS_CLUST_HI: ent_cluster[15:8] = b;
      POS_SIZE_B0:  ent_size[7:0] = b;
      POS_SIZE_B1:  ent_size[15:8] = b;
      POS_SIZE_B2:  ent_size[23:16] = b;
      POS_SIZE_B3:  ent_size[31:24] = b;
      default: ;
    endcase
    ent_pos = p + 5'd1;
    if (p != POS_LAST) return;
    r = '0;
    if (dir_ended) begin
      r.entry_kind = KIND_AFTER_END;
    end else if (ent_lead == LEAD_END) begin
      r.entry_kind = KIND_END;
      dir_ended = 1'b1;
    end else if (ent_lead == LEAD_DELETED) begin
      r.entry_kind = KIND_DELETED;
    end else if (ent_attr == ATTR_LONGNAME) begin
      r.entry_kind = KIND_LONGNAME;
    end else if (ent_cluster[15:1] == '0) begin
      r.entry_kind = KIND_RESERVED;
    end else begin
      r.entry_kind    = ent_attr[ATTR_DIR_BIT] ? KIND_DIR : KIND_FILE;
      r.attributes    = ent_attr;
      r.first_cluster = ent_cluster;
      r.file_size     = ent_size;
      r.year          = YEAR_BASE + {5'd0, ent_date[15:9]};
      r.month         = ent_date[8:5];
      r.day           = ent_date[4:0];
      r.hour          = ent_time[15:11];
      r.minute        = ent_time[10:5];
      r.second        = {ent_time[4:0], 1'b0};
    end
    entry_results_q.push_back(r);
  endfunction

  task automatic add_entry(input logic [7:0] lead, input logic [7:0] attr,
                           input logic [15:0] tm, input logic [15:0] dt,
                           input logic [15:0] cl, input logic [31:0] sz,
                           input logic sod);
    logic [7:0] e[32];
    dir_byte_t  it;
    for (int k = 0; k < 32; k++) e[k] = 8'($urandom);
    e[0]  = lead;
    e[11] = attr;
    e[14] = tm[7:0];
    e[15] = tm[15:8];
    e[16] = dt[7:0];
    e[17] = dt[15:8];
    e[26] = cl[7:0];
    e[27] = cl[15:8];
    e[28] = sz[7:0];
    e[29] = sz[15:8];
    e[30] = sz[23:16];
    e[31] = sz[31:24];
    for (int k = 0; k < 32; k++) begin
      it.data = e[k];
      it.sod  = (k == 0) ? sod : 1'b0;
      dir_bytes_q.push_back(it);
    end
  endtask

  task automatic add_random_entry(input logic allow_end, input logic sod);
    logic [7:0]  lead;
    logic [7:0]  attr;
    logic [15:0] cl;
    logic [31:0] sz;
    case ($urandom_range(0, 19))
      0:       lead = LEAD_DELETED;
      1:       lead = allow_end ? LEAD_END : 8'h2E;
      default: lead = 8'($urandom_range(1, 255));
    endcase
    attr = ($urandom_range(0, 7) == 0) ? ATTR_LONGNAME : 8'($urandom);
    cl   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom);
    case ($urandom_range(0, 15))
      0:       sz = 32'hFFFF_FFFF;
      1:       sz = 32'h0;
      default: sz = $urandom;
    endcase
    add_entry(lead, attr, 16'($urandom), 16'($urandom), cl, sz, sod);
  endtask

  task automatic build_stimulus();
    dir_byte_t it;
    int        n_ent;
    int        end_at;
    int        base;
    add_entry(8'h41, 8'h00, 16'h0000, 16'h0000, 16'h0002, 32'h0, 1'b1);
    add_entry(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_entry(8'h42, 8'h10, 16'hA5C3, 16'h5A3C, 16'h8001, 32'h1234_5678, 1'b0);
    add_entry(8'h43, 8'hEF, 16'hBF7D, 16'hFE1F, 16'h0FF7, 32'h8000_0001, 1'b0);
    add_entry(LEAD_DELETED, ATTR_LONGNAME, 16'h1111, 16'h2222, 16'h0000, 32'h5, 1'b0);
    add_entry(8'h44, ATTR_LONGNAME, 16'h0, 16'h0, 16'h0000, 32'h0, 1'b0);
    add_entry(8'h45, 8'h20, 16'h7BBF, 16'h9F9F, 16'h0000, 32'h100, 1'b0);
    add_entry(8'h46, 8'h10, 16'h7BBF, 16'h9F9F, 16'h0001, 32'h100, 1'b0);
    add_entry(8'h05, 8'h00, 16'hBFFF, 16'h01BF, 16'h0100, 32'hFF, 1'b0);
    add_entry(LEAD_END, 8'h00, 16'h1234, 16'h4321, 16'h0005, 32'h77, 1'b0);
    add_entry(8'h47, 8'h00, 16'h1234, 16'h4321, 16'h0005, 32'h77, 1'b0);
    add_entry(LEAD_END, 8'h10, 16'h0, 16'h0, 16'h0003, 32'h0, 1'b0);
    for (int k = 0; k < 13; k++) begin
      it.data = 8'($urandom);
      it.sod  = (k == 0);
      dir_bytes_q.push_back(it);
    end
    add_entry(8'h48, 8'h01, 16'h4321, 16'h1234, 16'h0FFF, 32'h0001_0000, 1'b1);
    add_entry(LEAD_END, 8'h00, 16'h0, 16'h0, 16'h0, 32'h0, 1'b0);
    add_entry(8'h49, 8'h00, 16'h0, 16'h0, 16'h0009, 32'h9, 1'b1);

    base = dir_bytes_q.size();
    while (dir_bytes_q.size() < base + 1400) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 40)) begin
          it.data = 8'($urandom);
          it.sod  = ($urandom_range(0, 7) == 0);
          dir_bytes_q.push_back(it);
        end
      end else begin
        n_ent  = $urandom_range(1, 10);
        end_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_ent - 1) : n_ent;
        for (int k = 0; k < n_ent; k++) begin
          if (k == end_at) begin
            add_entry(LEAD_END, 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), $urandom, (k == 0));
          end else begin
            add_random_entry(k > end_at, (k == 0) && ($urandom_range(0, 9) != 0));
          end
        end
      end
    end
    total_bytes = dir_bytes_q.size();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        decode_byte(in_data, in_sod);
        accepted_n = accepted_n + 1;
        if ($urandom_range(0, 63) == 0) in_idle_en <= !in_idle_en;
      end
      quiet <= (dir_bytes_q.size() < 150);
      if (!in_valid || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (dir_bytes_q.size() != 0 && !quiet && in_idle_en &&
                     $urandom_range(0, 5) == 0) begin
          in_gap   <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (dir_bytes_q.size() != 0) begin
          drv_item = dir_bytes_q.pop_front();
          in_data  <= drv_item.data;
          in_sod   <= drv_item.sod;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        got_entry.entry_kind    = kind_e'(entry_kind_o);
        got_entry.attributes    = attributes_o;
        got_entry.first_cluster = first_cluster_o;
        got_entry.file_size     = file_size_o;
        got_entry.year          = year_o;
        got_entry.month         = month_o;
        got_entry.day           = day_o;
        got_entry.hour          = hour_o;
        got_entry.minute        = minute_o;
        got_entry.second        = second_o;
        entries_seen = entries_seen + 1;
        if ($urandom_range(0, 15) == 0) out_idle_en <= !out_idle_en;
        if (entry_results_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("entry %0d: unexpected result, kind %0d", entries_seen, entry_kind_o);
        end else begin
          want_entry = entry_results_q.pop_front();
          if (got_entry !== want_entry) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $write("entry %0d: expected kind %0d attr %h clus %h size %h ",
                     entries_seen, want_entry.entry_kind, want_entry.attributes,
                     want_entry.first_cluster, want_entry.file_size);
              $display("%0d-%0d-%0d %0d:%0d:%0d", want_entry.year,
                       want_entry.month, want_entry.day, want_entry.hour,
                       want_entry.minute, want_entry.second);
              $write("entry %0d: actual   kind %0d attr %h clus %h size %h ",
                     entries_seen, got_entry.entry_kind, got_entry.attributes,
                     got_entry.first_cluster, got_entry.file_size);
              $display("%0d-%0d-%0d %0d:%0d:%0d", got_entry.year,
                       got_entry.month, got_entry.day, got_entry.hour,
                       got_entry.minute, got_entry.second);
            end
          end
        end
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (!quiet && out_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_n < total_bytes) @(posedge clk_i);
    for (int k = 0; k < 2000 && entry_results_q.size() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (entry_results_q.size() != 0) begin
      errors = errors + entry_results_q.size();
      $display("%0d expected entries never arrived", entry_results_q.size());
    end
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout after %0d of %0d bytes", accepted_n, total_bytes);
    $display("testbench: errors");
    $finish;
  end

endmodule
